// ----- hdl/photon_sample_packer_assert.svh -----
// assertion helpers shared by the checking code of the packer
`ifndef PHOTON_SAMPLE_PACKER_ASSERT_SVH
`define PHOTON_SAMPLE_PACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psp assertion failed");

`endif

// ----- hdl/psp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int REQ_TYPE_W     = 1;
    localparam int RAW_PINS_W     = 32;
    localparam int SAMPLE_NS_W    = 30;
    localparam int INTERVAL_W     = 16;
    localparam int COUNT_W        = 12;
    localparam int BLOCK_TOTAL_W  = 24;
    localparam int SECOND_TOTAL_W = 30;

    localparam int SPB_W          = 13;
    localparam int BPS_W          = 7;
    localparam int SAMPLE_IDX_W   = 12;
    localparam int BLOCK_IDX_W    = 6;

    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_BLOCK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_PER_SECOND = 1'b1;

    localparam logic [REQ_TYPE_W-1:0] REQ_START  = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE = 1'b1;

    localparam logic [SPB_W-1:0] SPB_RESET = 13'd1016;
    localparam logic [SPB_W-1:0] SPB_MAX   = 13'd4096;
    localparam logic [BPS_W-1:0] BPS_RESET = 7'd12;
    localparam logic [BPS_W-1:0] BPS_MAX   = 7'd64;

    localparam int LOW_BITS_POS  = 4;
    localparam int HIGH_BITS_POS = 16;
    localparam logic [RAW_PINS_W-1:0] LOW_MASK  = 32'h0000_03FF << LOW_BITS_POS;
    localparam logic [RAW_PINS_W-1:0] HIGH_MASK = 32'h0000_0003 << HIGH_BITS_POS;

    // modular time arithmetic is done on 32-bit two's complement values
    localparam int DIFF_W = 32;
    localparam logic [DIFF_W-1:0] NS_PER_SEC    = 32'd1000000000;
    localparam logic [DIFF_W-1:0] NS_PER_SEC_X2 = 32'd2000000000;

    // x / 1000 == ((x >> 3) * DIV_MUL) >> DIV_SHIFT, exact for x below 2^30
    localparam int DIV_IN_W  = SAMPLE_NS_W - 3;
    localparam int DIV_MUL_W = 28;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 28'd137438954;
    localparam int DIV_SHIFT = 34;
    localparam int PROD_W    = DIV_IN_W + DIV_MUL_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        logic [SAMPLE_NS_W-1:0]    diff_ns;
        logic [COUNT_W-1:0]        photon_count;
        logic                      block_end;
        logic [BLOCK_TOTAL_W-1:0]  block_total;
        logic                      second_end;
        logic [SECOND_TOTAL_W-1:0] second_total;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0]     interval_us;
        logic [COUNT_W-1:0]        photon_count;
        logic                      block_end;
        logic [BLOCK_TOTAL_W-1:0]  block_total;
        logic                      second_end;
        logic [SECOND_TOTAL_W-1:0] second_total;
    } res_item_t;

    function automatic logic [COUNT_W-1:0] gather_count(input logic [RAW_PINS_W-1:0] raw);
        logic [RAW_PINS_W-1:0] v;
        v = ((raw & LOW_MASK) >> 4) | ((raw & HIGH_MASK) >> 6);
        return v[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/psp_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface psp_req_if;
    import psp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [RAW_PINS_W-1:0]  raw_pins;
    logic [SAMPLE_NS_W-1:0] sample_ns;

    modport source (output valid, output req_type, output raw_pins, output sample_ns,
                    input ready);
    modport sink   (input valid, input req_type, input raw_pins, input sample_ns,
                    output ready);
endinterface

interface psp_res_if;
    import psp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [INTERVAL_W-1:0]     interval_us;
    logic [COUNT_W-1:0]        photon_count;
    logic                      block_end;
    logic [BLOCK_TOTAL_W-1:0]  block_total;
    logic                      second_end;
    logic [SECOND_TOTAL_W-1:0] second_total;

    modport source (output valid, output interval_us, output photon_count,
                    output block_end, output block_total, output second_end,
                    output second_total, input ready);
    modport sink   (input valid, input interval_us, input photon_count,
                    input block_end, input block_total, input second_end,
                    input second_total, output ready);
endinterface

`default_nettype wire

// ----- hdl/psp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [psp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    psp_req_if.sink                     req_ch,
    input  psp_pkg::queue_stat_t        q_stat,
    output logic                        q_push,
    output psp_pkg::queue_item_t        q_item
);
    import psp_pkg::*;

    logic [SAMPLE_NS_W-1:0]    last_ns_reg,    last_ns_next;
    logic [SAMPLE_IDX_W-1:0]   sample_idx_reg, sample_idx_next;
    logic [BLOCK_IDX_W-1:0]    block_idx_reg,  block_idx_next;
    logic [BLOCK_TOTAL_W-1:0]  block_sum_reg,  block_sum_next;
    logic [SECOND_TOTAL_W-1:0] second_sum_reg, second_sum_next;
    logic [SPB_W-1:0]          spb_reg,        spb_next;
    logic [BPS_W-1:0]          bps_reg,        bps_next;

    logic                      accept;
    logic [COUNT_W-1:0]        count;
    logic [DIFF_W-1:0]         d_raw;
    logic [DIFF_W-1:0]         d_lo;
    logic [DIFF_W-1:0]         d_hi1;
    logic [DIFF_W-1:0]         d_hi2;
    logic [DIFF_W-1:0]         d_mod;
    logic [SPB_W-1:0]          sample_inc;
    logic [BPS_W-1:0]          block_inc;
    logic                      bend;
    logic                      send;
    logic [BLOCK_TOTAL_W-1:0]  bsum_add;
    logic [SECOND_TOTAL_W-1:0] ssum_add;
    logic [BPS_W-1:0]          bps_wdata;

    assign req_ch.ready = !q_stat.full;
    assign accept       = req_ch.valid && req_ch.ready;
    assign q_push       = accept && (req_ch.req_type == REQ_SAMPLE);

    assign count = gather_count(req_ch.raw_pins);

    // time difference reduced into [0, 1e9)
    assign d_raw = DIFF_W'(req_ch.sample_ns) - DIFF_W'(last_ns_reg);
    assign d_lo  = d_raw - NS_PER_SEC;
    assign d_hi1 = d_raw + NS_PER_SEC;
    assign d_hi2 = d_raw + NS_PER_SEC_X2;

    always_comb
    begin
        if (!d_lo[DIFF_W-1])
        begin
            d_mod = d_lo;
        end
        else if (!d_raw[DIFF_W-1])
        begin
            d_mod = d_raw;
        end
        else if (!d_hi1[DIFF_W-1])
        begin
            d_mod = d_hi1;
        end
        else
        begin
            d_mod = d_hi2;
        end
    end

    assign sample_inc = SPB_W'(sample_idx_reg) + SPB_W'(1);
    assign block_inc  = BPS_W'(block_idx_reg) + BPS_W'(1);
    assign bend       = sample_inc >= spb_reg;
    assign send       = bend && (block_inc >= bps_reg);
    assign bsum_add   = block_sum_reg + BLOCK_TOTAL_W'(count);
    assign ssum_add   = second_sum_reg + SECOND_TOTAL_W'(bsum_add);

    always_comb
    begin
        q_item.diff_ns      = d_mod[SAMPLE_NS_W-1:0];
        q_item.photon_count = count;
        q_item.block_end    = bend;
        q_item.block_total  = bend ? bsum_add : '0;
        q_item.second_end   = send;
        q_item.second_total = send ? ssum_add : '0;
    end

    assign bps_wdata = cfg_wdata[BPS_W-1:0];

    always_comb
    begin
        spb_next = spb_reg;
        bps_next = bps_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_BLOCK:
                begin
                    if (cfg_wdata == '0)
                        spb_next = SPB_W'(1);
                    else if (cfg_wdata > SPB_MAX)
                        spb_next = SPB_MAX;
                    else
                        spb_next = cfg_wdata;
                end
                CFG_BLOCKS_PER_SECOND:
                begin
                    if (bps_wdata == '0)
                        bps_next = BPS_W'(1);
                    else if (bps_wdata > BPS_MAX)
                        bps_next = BPS_MAX;
                    else
                        bps_next = bps_wdata;
                end
                default:
                begin
                    spb_next = spb_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        last_ns_next    = last_ns_reg;
        sample_idx_next = sample_idx_reg;
        block_idx_next  = block_idx_reg;
        block_sum_next  = block_sum_reg;
        second_sum_next = second_sum_reg;
        if (accept)
        begin
            last_ns_next = req_ch.sample_ns;
            if (req_ch.req_type == REQ_START)
            begin
                sample_idx_next = '0;
                block_idx_next  = '0;
                block_sum_next  = '0;
                second_sum_next = '0;
            end
            else if (bend)
            begin
                sample_idx_next = '0;
                block_sum_next  = '0;
                if (send)
                begin
                    block_idx_next  = '0;
                    second_sum_next = '0;
                end
                else
                begin
                    block_idx_next  = block_inc[BLOCK_IDX_W-1:0];
                    second_sum_next = ssum_add;
                end
            end
            else
            begin
                sample_idx_next = sample_inc[SAMPLE_IDX_W-1:0];
                block_sum_next  = bsum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ns_reg    <= '0;
            sample_idx_reg <= '0;
            block_idx_reg  <= '0;
            block_sum_reg  <= '0;
            second_sum_reg <= '0;
            spb_reg        <= SPB_RESET;
            bps_reg        <= BPS_RESET;
        end
        else
        begin
            last_ns_reg    <= last_ns_next;
            sample_idx_reg <= sample_idx_next;
            block_idx_reg  <= block_idx_next;
            block_sum_reg  <= block_sum_next;
            second_sum_reg <= second_sum_next;
            spb_reg        <= spb_next;
            bps_reg        <= bps_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/psp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psp_pkg::queue_item_t push_item,
    input  logic                 pop,
    output psp_pkg::queue_item_t head_item,
    output psp_pkg::queue_stat_t stat
);
    import psp_pkg::*;

    queue_item_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   cnt_reg,    cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (cnt_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QUEUE_CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QUEUE_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- hdl/psp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psp_pkg::queue_stat_t q_stat,
    input  psp_pkg::queue_item_t head_item,
    output logic                 q_pop,
    psp_res_if.source            res_ch
);
    import psp_pkg::*;

    logic      a_valid_reg,   a_valid_next;
    logic      out_valid_reg, out_valid_next;
    res_item_t a_reg;
    res_item_t out_reg;

    logic              a_load;
    logic              b_load;
    logic [PROD_W-1:0] prod;

    // divide by 1000 through the reciprocal
    assign prod = PROD_W'(head_item.diff_ns[SAMPLE_NS_W-1:3]) * PROD_W'(DIV_MUL);

    assign b_load = !out_valid_reg || res_ch.ready;
    assign a_load = !a_valid_reg || b_load;
    assign q_pop  = a_load && !q_stat.empty;

    always_comb
    begin
        a_valid_next   = a_load ? !q_stat.empty : a_valid_reg;
        out_valid_next = b_load ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_reg.interval_us  <= prod[DIV_SHIFT +: INTERVAL_W];
            a_reg.photon_count <= head_item.photon_count;
            a_reg.block_end    <= head_item.block_end;
            a_reg.block_total  <= head_item.block_total;
            a_reg.second_end   <= head_item.second_end;
            a_reg.second_total <= head_item.second_total;
        end
        if (b_load && a_valid_reg)
            out_reg <= a_reg;
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.interval_us  = out_reg.interval_us;
    assign res_ch.photon_count = out_reg.photon_count;
    assign res_ch.block_end    = out_reg.block_end;
    assign res_ch.block_total  = out_reg.block_total;
    assign res_ch.second_end   = out_reg.second_end;
    assign res_ch.second_total = out_reg.second_total;

endmodule

`default_nettype wire

// ----- hdl/photon_sample_packer.sv -----
// channel   | dir | payload                                            | handshake
// req_ch    | in  | req_type, raw_pins, sample_ns                      | valid/ready
// res_ch    | out | interval_us, photon_count, block_end, block_total, | valid/ready
//           |     | second_end, second_total                           |
// cfg       | in  | cfg_index, cfg_wdata                               | cfg_we
//
// one item per cycle sustained while req_ch.ready is high; the front registers all counters and sums per item
// a sample item passes the queue slot, the reciprocal multiply stage and the output register
// in that order before it shows on res_ch; start items give no result
// reset clears counters, sums and reference time, registers go to 1016 and 12
// a stalled res_ch fills the two back stages and the 4-entry queue, then req_ch.ready drops
`timescale 1ns / 1ps
`default_nettype none
`include "photon_sample_packer_assert.svh"

module photon_sample_packer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    psp_req_if.sink                         req_ch,
    psp_res_if.source                       res_ch
);
    import psp_pkg::*;

    queue_stat_t q_stat;
    queue_item_t q_item;
    queue_item_t head_item;
    logic        q_push;
    logic        q_pop;

    psp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_ch),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    psp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    psp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_item (head_item),
        .q_pop     (q_pop),
        .res_ch    (res_ch)
    );

    `PSP_ASSERT_IMPL(a_no_push_full, q_stat.full, !q_push)
    `PSP_ASSERT_IMPL(a_second_in_block, res_ch.valid && res_ch.second_end, res_ch.block_end)
    `PSP_ASSERT_IMPL(a_block_total_zero, res_ch.valid && !res_ch.block_end, res_ch.block_total == '0)
    `PSP_ASSERT_IMPL(a_second_total_zero, res_ch.valid && !res_ch.second_end, res_ch.second_total == '0)

endmodule

`default_nettype wire
